// ----- sv/dq_pkg.sv -----
// Shared definitions for the double-ended queue: operation and status codes,
// default depth, and the controller-to-datapath command and status structs.
// No dependencies.
package dq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_PEEK       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic latch;   // capture the incoming item
    logic update;  // apply the operation: pointers, count, slot write
    logic read;    // read front and back slots
    logic load;    // load the result register
  } dq_cmd_t;

  typedef struct packed {
    logic out_busy; // result register holds an item that is stalled
  } dq_sts_t;

endpackage

// ----- sv/double_ended_queue.sv -----
// Top level of the double-ended queue: joins the sequencer and the datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_func, in_value
//   out_     output     out_valid / out_stall out_front_value, out_back_value,
//                                            out_occupancy, out_is_empty, out_status
//
// An item passes through capture, pointer update with slot write, registered
// read of the front and back slots, and result load. The next item is accepted
// once the sequencer is back in idle after the load step.
// The single-write, two-read slot store sets that sequence.
// Reset (rst_n low, synchronous) empties the queue; slot contents stay as they are.
// A stalled result holds in its register; the next item is accepted meanwhile
// and waits at the load step until the result is taken.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dq_pkg::FUNC_W-1:0]            in_func,
  input  logic signed [dq_pkg::VALUE_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dq_pkg::VALUE_W-1:0]    out_front_value,
  output logic signed [dq_pkg::VALUE_W-1:0]    out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]           out_occupancy,
  output logic                                 out_is_empty,
  output logic [dq_pkg::STATUS_W-1:0]          out_status
);

  dq_pkg::dq_cmd_t cmd;
  dq_pkg::dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule

// ----- sv/dq_ctrl.sv -----
// Sequencer for the double-ended queue: walks each item through capture,
// update, slot read and result load. Depends on dq_pkg.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output dq_pkg::dq_cmd_t cmd,
  input  dq_pkg::dq_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_RD;
      end
      S_RD: begin
        cmd.read  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // hold until the previous result has been taken
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/dq_datapath.sv -----
// Datapath for the double-ended queue: item capture, front pointer and count,
// the circular slot store, and the result register. Depends on dq_pkg.
module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dq_pkg::dq_cmd_t                      cmd,
  output dq_pkg::dq_sts_t                      sts,
  input  logic [dq_pkg::FUNC_W-1:0]            in_func,
  input  logic signed [dq_pkg::VALUE_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dq_pkg::VALUE_W-1:0]    out_front_value,
  output logic signed [dq_pkg::VALUE_W-1:0]    out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]           out_occupancy,
  output logic                                 out_is_empty,
  output logic [dq_pkg::STATUS_W-1:0]          out_status
);

  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);
  localparam int SW   = IDXW + 1;

  logic signed [dq_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [dq_pkg::FUNC_W-1:0]         op_r;
  logic signed [dq_pkg::VALUE_W-1:0] val_r;
  logic [IDXW-1:0]                   front_r, front_nxt;
  logic [CNTW-1:0]                   count_r, count_nxt;
  logic [dq_pkg::STATUS_W-1:0]       status_r, status_nxt;
  logic                              wr_en;
  logic [IDXW-1:0]                   wr_addr;
  logic [SW-1:0]                     tail_sum, back_sum;
  logic [IDXW-1:0]                   tail_idx, back_idx;
  logic                              full, empty;
  logic signed [dq_pkg::VALUE_W-1:0] rd_front_r, rd_back_r;
  logic                              out_valid_r;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);

  // slot just past the back; count is below DEPTH here, so one subtract wraps it
  assign tail_sum = SW'(front_r) + SW'(count_r);
  assign tail_idx = (tail_sum >= SW'(DEPTH)) ? IDXW'(tail_sum - SW'(DEPTH))
                                             : IDXW'(tail_sum);

  assign back_sum = SW'(front_r) + SW'(count_r) - SW'(1);
  always_comb begin
    if (empty) begin
      back_idx = front_r;
    end else if (back_sum >= SW'(DEPTH)) begin
      back_idx = IDXW'(back_sum - SW'(DEPTH));
    end else begin
      back_idx = IDXW'(back_sum);
    end
  end

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    case (op_r)
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          front_nxt = (front_r == '0) ? IDXW'(DEPTH - 1) : front_r - IDXW'(1);
          wr_addr   = front_nxt;
          wr_en     = cmd.update;
          count_nxt = count_r + CNTW'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          wr_en     = cmd.update;
          count_nxt = count_r + CNTW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          front_nxt = (front_r == IDXW'(DEPTH - 1)) ? '0 : front_r + IDXW'(1);
          count_nxt = count_r - CNTW'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CNTW'(1);
        end
      end
      default: begin
        // peek and unused codes leave the store alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_func;
      val_r <= in_value;
    end
    if (cmd.update) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_front_value <= empty ? '0 : rd_front_r;
      out_back_value  <= empty ? '0 : rd_back_r;
      out_occupancy   <= count_r;
      out_is_empty    <= empty;
      out_status      <= status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// Testbench for double_ended_queue: directed corner items, then random push/pop
// traffic under several idle and stall mixes, checked against a behavioral deque.
// Depends on dq_pkg and the double_ended_queue RTL.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W       = dq_pkg::FUNC_W;
  localparam int VALUE_W      = dq_pkg::VALUE_W;
  localparam int STATUS_W     = dq_pkg::STATUS_W;
  localparam int DEPTH        = dq_pkg::DEPTH_DEF;
  localparam int OCC_W        = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_LEN   = 16;
  localparam int PHASE_ITEMS  = 256;

  typedef struct {
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
    logic [OCC_W-1:0]           occupancy;
    logic                       is_empty;
    logic [STATUS_W-1:0]        status;
  } deque_view_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [FUNC_W-1:0]          in_func;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [VALUE_W-1:0]  out_front_value;
  logic signed [VALUE_W-1:0]  out_back_value;
  logic [OCC_W-1:0]           out_occupancy;
  logic                       out_is_empty;
  logic [STATUS_W-1:0]        out_status;

  // behavioral copy of the deque
  logic signed [VALUE_W-1:0]  model_slots [DEPTH];
  int unsigned                model_front;
  int unsigned                model_count;

  deque_view_t                expected_views[$];
  int                         error_count;
  int                         cycle_count;
  int                         idle_pct;
  int                         stall_pct;

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               expected_views.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic deque_view_t apply_operation(input logic [FUNC_W-1:0] func,
                                                  input logic signed [VALUE_W-1:0] value);
    deque_view_t view;
    view.status = dq_pkg::ST_OK;
    case (func)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          view.status = dq_pkg::ST_FULL;
        end else if (func == dq_pkg::OP_PUSH_FRONT) begin
          model_front = (model_front + DEPTH - 1) % DEPTH;
          model_slots[model_front] = value;
          model_count++;
        end else begin
          model_slots[(model_front + model_count) % DEPTH] = value;
          model_count++;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (model_count == 0) begin
          view.status = dq_pkg::ST_EMPTY;
        end else begin
          if (func == dq_pkg::OP_POP_FRONT) model_front = (model_front + 1) % DEPTH;
          model_count--;
        end
      end
      default: ;  // peek and the unused codes leave the deque alone
    endcase
    view.front_value = '0;
    view.back_value  = '0;
    if (model_count != 0) begin
      view.front_value = model_slots[model_front];
      view.back_value  = model_slots[(model_front + model_count - 1) % DEPTH];
    end
    view.occupancy = model_count[OCC_W-1:0];
    view.is_empty  = (model_count == 0);
    return view;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_views.push_back(apply_operation(in_func, in_value));
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected item, queue depth", 1, 0);
      end else begin
        want = expected_views.pop_front();
        if (out_front_value !== want.front_value)
          report_mismatch("front_value", out_front_value, want.front_value);
        if (out_back_value !== want.back_value)
          report_mismatch("back_value", out_back_value, want.back_value);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", out_occupancy, want.occupancy);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", out_is_empty, want.is_empty);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
    end
  end

  // Hold the item until it is taken; idle gaps go in front of it.
  task automatic send_item(input logic [FUNC_W-1:0] func,
                           input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_func  <= FUNC_W'($urandom);
      in_value <= $urandom;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Pause the sender until every outstanding item has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_store();
    send_item(dq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    send_item(dq_pkg::OP_POP_BACK, -32'sd1);
    send_item(dq_pkg::OP_PEEK, 32'sh7FFF_FFFF);
    send_item(3'd5, 32'sh8000_0000);
    send_item(3'd6, 32'sh0);
    send_item(3'd7, 32'sh5555_AAAA);
  endtask

  task automatic test_fill_and_overflow();
    logic signed [VALUE_W-1:0] extremes [4];
    extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1};
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2 == 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                extremes[i % 4]);
    end
    send_item(dq_pkg::OP_PUSH_FRONT, 32'sh0BAD_F00D);
    send_item(dq_pkg::OP_PUSH_BACK, 32'shAAAA_5555);
    send_item(dq_pkg::OP_POP_FRONT, 32'sh0);
    send_item(dq_pkg::OP_POP_BACK, 32'sh0);
  endtask

  // Bursts lean toward pushes, toward pops or toward neither, so the store keeps hitting full and empty.
  task automatic test_random_traffic(input int n_items, input int idle, input int stall);
    int                 sent;
    int                 burst;
    int                 push_pct;
    int                 pop_pct;
    int                 roll;
    logic [FUNC_W-1:0]  func;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0:       begin push_pct = 70; pop_pct = 20; end
        1:       begin push_pct = 20; pop_pct = 70; end
        default: begin push_pct = 42; pop_pct = 42; end
      endcase
      burst = $urandom_range(40, 8);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        roll = $urandom_range(99);
        if (roll < push_pct)
          func = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
        else if (roll < push_pct + pop_pct)
          func = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
        else
          func = FUNC_W'($urandom_range(7, 4));
        send_item(func, pick_value());
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = '0;
    in_value    = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    model_front = 0;
    model_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_fill_and_overflow();
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 80, 0);
    test_random_traffic(PHASE_ITEMS, 0, 80);
    test_random_traffic(PHASE_ITEMS, 8, 8);

    stall_pct = 0;
    repeat (SETTLE_LEN) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
